// File: hw/rtl/tsb_pkg.sv
// ----------------------------------------------------------------------------
// tsb_pkg
// Shared constants, codes and control types of the terminal scroll buffer.
// ----------------------------------------------------------------------------
package tsb_pkg;

  localparam int MAX_COLUMNS = 64;
  localparam int MAX_ROWS    = 32;

  localparam int COL_W     = $clog2(MAX_COLUMNS);
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int ADDR_W    = ROW_W + COL_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;

  // Counts that must also hold the full column or row count.
  localparam int COLCNT_W = $clog2(MAX_COLUMNS + 1);
  localparam int ROWCNT_W = $clog2(MAX_ROWS + 1);

  localparam int CHAR_W = 8;
  localparam logic [CHAR_W-1:0] BLANK_CHAR      = 8'd32;
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR    = 8'd10;
  localparam logic [CHAR_W-1:0] FIRST_PRINTABLE = 8'd32;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = (COLCNT_W > ROWCNT_W) ? COLCNT_W : ROWCNT_W;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_COLUMNS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_ROWS    = 2'd1;
  localparam logic [COLCNT_W-1:0]  ACTIVE_COLUMNS_RST = COLCNT_W'(MAX_COLUMNS);
  localparam logic [ROWCNT_W-1:0]  ACTIVE_ROWS_RST    = ROWCNT_W'(MAX_ROWS);

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_HOME  = 2'd2,
    CMD_READ  = 2'd3
  } tsb_cmd_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_CLEAR,
    ST_SCROLL_INIT,
    ST_COPY,
    ST_DRAIN,
    ST_BLANK,
    ST_APPLY,
    ST_FINISH
  } tsb_state_e;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_TAKE,
    DP_SWEEP,
    DP_HOME,
    DP_READ,
    DP_COPY_INIT,
    DP_COPY,
    DP_DRAIN,
    DP_BLANK,
    DP_APPLY
  } tsb_op_e;

  typedef struct packed {
    tsb_op_e op;
    logic    out_load;
  } tsb_ctl_t;

  typedef struct packed {
    tsb_cmd_e cmd;
    logic     need_scroll;
    logic     rows_one;
    logic     copy_last;
    logic     blank_last;
    logic     sweep_last;
    logic     out_free;
  } tsb_status_t;

endpackage

// File: hw/rtl/tsb_if.sv
// ----------------------------------------------------------------------------
// tsb_if
// Handshake channels of the terminal scroll buffer: items, results, config.
// ----------------------------------------------------------------------------
interface tsb_item_if import tsb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic [CHAR_W-1:0] char_code;
  logic [ROW_W-1:0]  read_row;
  logic [COL_W-1:0]  read_column;

  modport source (output valid, command, char_code, read_row, read_column, input ready);
  modport sink   (input valid, command, char_code, read_row, read_column, output ready);
endinterface

interface tsb_result_if import tsb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CHAR_W-1:0]   cell_value;
  logic [COL_W-1:0]    cursor_column;
  logic [ROWCNT_W-1:0] cursor_row;
  logic                char_stored;
  logic                screen_scrolled;
  logic                line_advanced;

  modport source (output valid, cell_value, cursor_column, cursor_row, char_stored,
                  screen_scrolled, line_advanced, input ready);
  modport sink   (input valid, cell_value, cursor_column, cursor_row, char_stored,
                  screen_scrolled, line_advanced, output ready);
endinterface

interface tsb_cfg_if import tsb_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/tsb_ctrl.sv
// ----------------------------------------------------------------------------
// tsb_ctrl
// Sequencer: takes each item from decode to result, via a clear sweep or a scroll and update as needed.
// ----------------------------------------------------------------------------
module tsb_ctrl import tsb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        item_valid_i,
  output logic        item_ready_o,
  input  tsb_status_t status_i,
  output tsb_ctl_t    ctl_o
);

  tsb_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        if (status_i.sweep_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (item_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        unique case (status_i.cmd) inside
          CMD_WRITE:          state_d = status_i.need_scroll ? ST_SCROLL_INIT : ST_APPLY;
          CMD_CLEAR:          state_d = ST_CLEAR;
          CMD_HOME, CMD_READ: state_d = ST_FINISH;
          default:            state_d = ST_FINISH;
        endcase
      end
      ST_CLEAR: begin
        if (status_i.sweep_last) state_d = ST_FINISH;
      end
      ST_SCROLL_INIT: begin
        state_d = status_i.rows_one ? ST_DRAIN : ST_COPY;
      end
      ST_COPY: begin
        if (status_i.copy_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_d = ST_BLANK;
      end
      ST_BLANK: begin
        if (status_i.blank_last) state_d = ST_APPLY;
      end
      ST_APPLY: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl_o.op       = DP_NOP;
    ctl_o.out_load = 1'b0;
    item_ready_o   = 1'b0;
    unique case (state_q)
      ST_INIT:  ctl_o.op = DP_SWEEP;
      ST_IDLE: begin
        item_ready_o = 1'b1;
        if (item_valid_i) ctl_o.op = DP_TAKE;
      end
      ST_EXEC: begin
        unique case (status_i.cmd) inside
          CMD_WRITE:           ctl_o.op = DP_NOP;
          CMD_CLEAR, CMD_HOME: ctl_o.op = DP_HOME;
          CMD_READ:            ctl_o.op = DP_READ;
          default:             ctl_o.op = DP_NOP;
        endcase
      end
      ST_CLEAR:       ctl_o.op = DP_SWEEP;
      ST_SCROLL_INIT: ctl_o.op = DP_COPY_INIT;
      ST_COPY:        ctl_o.op = DP_COPY;
      ST_DRAIN:       ctl_o.op = DP_DRAIN;
      ST_BLANK:       ctl_o.op = DP_BLANK;
      ST_APPLY:       ctl_o.op = DP_APPLY;
      ST_FINISH:      ctl_o.out_load = status_i.out_free;
      default:        ctl_o.op = DP_NOP;
    endcase
  end

  // The cursor update follows either the decode step or the end of a scroll.
  a_apply_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_APPLY |-> $past(state_q) == ST_EXEC || $past(state_q) == ST_BLANK)
    else $error("cursor update entered from an unexpected phase");

  a_finish_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FINISH && !status_i.out_free |=> state_q == ST_FINISH)
    else $error("result phase left while the output register was occupied");

endmodule

// File: hw/rtl/tsb_datapath.sv
// ----------------------------------------------------------------------------
// tsb_datapath
// Screen memory, cursor, configuration, sweep counters and result register.
// ----------------------------------------------------------------------------
module tsb_datapath import tsb_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tsb_ctl_t              ctl_i,
  output tsb_status_t           status_o,
  input  logic [1:0]            command_i,
  input  logic [CHAR_W-1:0]     char_code_i,
  input  logic [ROW_W-1:0]      read_row_i,
  input  logic [COL_W-1:0]      read_column_i,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [CHAR_W-1:0]     cell_value_o,
  output logic [COL_W-1:0]      cursor_column_o,
  output logic [ROWCNT_W-1:0]   cursor_row_o,
  output logic                  char_stored_o,
  output logic                  screen_scrolled_o,
  output logic                  line_advanced_o
);

  // Configuration and effective (saturated) sizes.
  logic [COLCNT_W-1:0] act_cols_q, eff_cols;
  logic [ROWCNT_W-1:0] act_rows_q, eff_rows;
  logic [COL_W-1:0]    last_col;
  logic [ROW_W-1:0]    last_row;

  // Latched item.
  tsb_cmd_e          itm_cmd_q;
  logic [CHAR_W-1:0] itm_char_q;
  logic [ROW_W-1:0]  itm_rrow_q;
  logic [COL_W-1:0]  itm_rcol_q;

  // Cursor and per-item flags.
  logic [COL_W-1:0]    col_q, col_d;
  logic [ROWCNT_W-1:0] row_q, row_d;
  logic                stored_q, stored_d;
  logic                adv_q, adv_d;
  logic                scrolled_q, scrolled_d;

  // Sweep and scroll position, pending copy write.
  logic [ROW_W-1:0]  sr_q, sr_d;
  logic [COL_W-1:0]  sc_q, sc_d;
  logic              pend_q, pend_d;
  logic [ADDR_W-1:0] pend_addr_q;

  // Screen memory.
  logic [CHAR_W-1:0] screen_q [MEM_DEPTH];
  logic [CHAR_W-1:0] rdata_q;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [CHAR_W-1:0] mem_wdata;

  // Result register.
  logic                out_valid_q;
  logic [CHAR_W-1:0]   out_cell_q;
  logic [COL_W-1:0]    out_col_q;
  logic [ROWCNT_W-1:0] out_row_q;
  logic                out_stored_q, out_scrolled_q, out_adv_q;

  logic                is_nl, is_print, rd_hit, out_free;
  logic [COLCNT_W-1:0] c_base, c_inc;
  logic [ROWCNT_W-1:0] r_base;
  logic                store_ok;

  always_comb begin
    if (act_cols_q == '0) begin
      eff_cols = COLCNT_W'(1);
    end else if (act_cols_q > COLCNT_W'(MAX_COLUMNS)) begin
      eff_cols = COLCNT_W'(MAX_COLUMNS);
    end else begin
      eff_cols = act_cols_q;
    end
    if (act_rows_q == '0) begin
      eff_rows = ROWCNT_W'(1);
    end else if (act_rows_q > ROWCNT_W'(MAX_ROWS)) begin
      eff_rows = ROWCNT_W'(MAX_ROWS);
    end else begin
      eff_rows = act_rows_q;
    end
  end

  assign last_col = COL_W'(eff_cols - COLCNT_W'(1));
  assign last_row = ROW_W'(eff_rows - ROWCNT_W'(1));

  assign is_nl    = (itm_char_q == NEWLINE_CHAR);
  assign is_print = (itm_char_q >= FIRST_PRINTABLE);
  assign rd_hit   = (ROWCNT_W'(itm_rrow_q) < eff_rows) && (COLCNT_W'(itm_rcol_q) < eff_cols);
  assign out_free = !out_valid_q || out_ready_i;

  // After a scroll taken for a printable character the write lands at the
  // start of the last row.
  assign c_base   = scrolled_q ? '0 : COLCNT_W'(col_q);
  assign r_base   = scrolled_q ? ROWCNT_W'(last_row) : row_q;
  assign c_inc    = c_base + COLCNT_W'(1);
  assign store_ok = (c_base < eff_cols);

  always_comb begin
    status_o.cmd         = itm_cmd_q;
    status_o.need_scroll = (itm_cmd_q == CMD_WRITE) && (is_nl || is_print) && (row_q >= eff_rows);
    status_o.rows_one    = (last_row == '0);
    status_o.copy_last   = (sr_q == last_row) && (sc_q == last_col);
    status_o.blank_last  = (sc_q == last_col);
    status_o.sweep_last  = &{sr_q, sc_q};
    status_o.out_free    = out_free;
  end

  // Cursor and flag update.
  always_comb begin
    col_d      = col_q;
    row_d      = row_q;
    stored_d   = stored_q;
    adv_d      = adv_q;
    scrolled_d = scrolled_q;
    case (ctl_i.op)
      DP_TAKE: begin
        stored_d   = 1'b0;
        adv_d      = 1'b0;
        scrolled_d = 1'b0;
      end
      DP_HOME: begin
        col_d = '0;
        row_d = '0;
      end
      DP_COPY_INIT: scrolled_d = 1'b1;
      DP_APPLY: begin
        if (is_nl) begin
          col_d = '0;
          if (!scrolled_q) begin
            row_d = ROWCNT_W'(row_q + ROWCNT_W'(1));
            adv_d = 1'b1;
          end
        end else if (is_print) begin
          stored_d = store_ok;
          if (c_inc >= eff_cols) begin
            col_d = '0;
            row_d = ROWCNT_W'(r_base + ROWCNT_W'(1));
            adv_d = 1'b1;
          end else begin
            col_d = c_inc[COL_W-1:0];
            row_d = r_base;
          end
        end
      end
      default: ;
    endcase
  end

  // Position counters: a plain address walk for sweeps, a row and column
  // scan over the active area for scrolling.
  always_comb begin
    sr_d   = sr_q;
    sc_d   = sc_q;
    pend_d = pend_q;
    case (ctl_i.op)
      DP_TAKE: begin
        sr_d = '0;
        sc_d = '0;
      end
      DP_SWEEP: {sr_d, sc_d} = {sr_q, sc_q} + ADDR_W'(1);
      DP_COPY_INIT: begin
        sr_d   = ROW_W'(1);
        sc_d   = '0;
        pend_d = 1'b0;
      end
      DP_COPY: begin
        pend_d = 1'b1;
        if (sc_q == last_col) begin
          sc_d = '0;
          sr_d = sr_q + ROW_W'(1);
        end else begin
          sc_d = sc_q + COL_W'(1);
        end
      end
      DP_DRAIN: begin
        pend_d = 1'b0;
        sr_d   = last_row;
        sc_d   = '0;
      end
      DP_BLANK: sc_d = sc_q + COL_W'(1);
      default: ;
    endcase
  end

  // Memory port selection.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {sr_q, sc_q};
    mem_wdata = BLANK_CHAR;
    mem_re    = 1'b0;
    mem_raddr = {sr_q, sc_q};
    unique case (ctl_i.op)
      DP_SWEEP, DP_BLANK: mem_we = 1'b1;
      DP_COPY: begin
        mem_we    = pend_q;
        mem_waddr = pend_addr_q;
        mem_wdata = rdata_q;
        mem_re    = 1'b1;
      end
      DP_DRAIN: begin
        mem_we    = pend_q;
        mem_waddr = pend_addr_q;
        mem_wdata = rdata_q;
      end
      DP_READ: begin
        mem_re    = 1'b1;
        mem_raddr = {itm_rrow_q, itm_rcol_q};
      end
      DP_APPLY: begin
        mem_we    = is_print && !is_nl && store_ok;
        mem_waddr = {r_base[ROW_W-1:0], c_base[COL_W-1:0]};
        mem_wdata = itm_char_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      screen_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= screen_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_cols_q  <= ACTIVE_COLUMNS_RST;
      act_rows_q  <= ACTIVE_ROWS_RST;
      col_q       <= '0;
      row_q       <= '0;
      stored_q    <= 1'b0;
      adv_q       <= 1'b0;
      scrolled_q  <= 1'b0;
      sr_q        <= '0;
      sc_q        <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_ACTIVE_COLUMNS: act_cols_q <= cfg_data_i[COLCNT_W-1:0];
          REG_ACTIVE_ROWS:    act_rows_q <= cfg_data_i[ROWCNT_W-1:0];
          default: ;
        endcase
      end
      col_q      <= col_d;
      row_q      <= row_d;
      stored_q   <= stored_d;
      adv_q      <= adv_d;
      scrolled_q <= scrolled_d;
      sr_q       <= sr_d;
      sc_q       <= sc_d;
      pend_q     <= pend_d;
      if (ctl_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.op == DP_TAKE) begin
      itm_cmd_q  <= tsb_cmd_e'(command_i);
      itm_char_q <= char_code_i;
      itm_rrow_q <= read_row_i;
      itm_rcol_q <= read_column_i;
    end
    if (ctl_i.op == DP_COPY) begin
      pend_addr_q <= {ROW_W'(sr_q - ROW_W'(1)), sc_q};
    end
    if (ctl_i.out_load) begin
      out_cell_q     <= ((itm_cmd_q == CMD_READ) && rd_hit) ? rdata_q : '0;
      out_col_q      <= col_q;
      out_row_q      <= row_q;
      out_stored_q   <= stored_q;
      out_scrolled_q <= scrolled_q;
      out_adv_q      <= adv_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign cell_value_o      = out_cell_q;
  assign cursor_column_o   = out_col_q;
  assign cursor_row_o      = out_row_q;
  assign char_stored_o     = out_stored_q;
  assign screen_scrolled_o = out_scrolled_q;
  assign line_advanced_o   = out_adv_q;

  // The last copy write must have landed before the character is stored.
  a_copy_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.op == DP_APPLY |-> !pend_q)
    else $error("character stored while a scroll copy write was outstanding");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.out_load |-> !out_valid_q || out_ready_i)
    else $error("result register loaded over an item not yet taken");

  a_read_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_cell_q != '0) |-> !out_stored_q && !out_scrolled_q && !out_adv_q)
    else $error("cell read reported a screen change");

endmodule

// File: hw/rtl/text_terminal_scroll_buffer_core.sv
// ----------------------------------------------------------------------------
// text_terminal_scroll_buffer_core: character-cell terminal with scrolling.
// Items are taken one at a time; the result is valid from the cycle in which the
// block is ready for the next item. A scroll copies rows up one cell per cycle on
// the RAM, then blanks the last row. Clear blanks the whole screen memory and
// homes the cursor; after reset a blanking sweep of the whole memory runs first.
// ----------------------------------------------------------------------------
module text_terminal_scroll_buffer_core import tsb_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  tsb_item_if.sink       item_i,
  tsb_result_if.source   result_o,
  tsb_cfg_if.sink        cfg_i
);

  tsb_ctl_t    ctl;
  tsb_status_t status;

  // Register writes are taken on any cycle.
  assign cfg_i.ready = 1'b1;

  tsb_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_i.valid),
    .item_ready_o (item_i.ready),
    .status_i     (status),
    .ctl_o        (ctl)
  );

  tsb_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .ctl_i             (ctl),
    .status_o          (status),
    .command_i         (item_i.command),
    .char_code_i       (item_i.char_code),
    .read_row_i        (item_i.read_row),
    .read_column_i     (item_i.read_column),
    .cfg_valid_i       (cfg_i.valid),
    .cfg_index_i       (cfg_i.index),
    .cfg_data_i        (cfg_i.data),
    .out_ready_i       (result_o.ready),
    .out_valid_o       (result_o.valid),
    .cell_value_o      (result_o.cell_value),
    .cursor_column_o   (result_o.cursor_column),
    .cursor_row_o      (result_o.cursor_row),
    .char_stored_o     (result_o.char_stored),
    .screen_scrolled_o (result_o.screen_scrolled),
    .line_advanced_o   (result_o.line_advanced)
  );

endmodule
